@@ design/drl_pkg.sv @@
// Shared types and opcodes for the dirty rectangle list.
`timescale 1ns / 1ps
package drl_pkg;

   localparam int OP_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 3'd0,
      OP_CLIP  = 3'd1,
      OP_SHIFT = 3'd2,
      OP_CLEAR = 3'd3,
      OP_UNION = 3'd4,
      OP_READ  = 3'd5,
      OP_NOP6  = 3'd6,
      OP_NOP7  = 3'd7
   } op_type;

   // Datapath commands issued by the controller
   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STEP  = 3'd2,
      CMD_FINAL = 3'd3,
      CMD_ZERO  = 3'd4,
      CMD_EMIT  = 3'd5
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } drl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic stop;
      logic zero_done;
      logic read_last;
      logic read_empty;
   } drl_status_type;

endpackage

@@ design/drl_if.sv @@
// Valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface drl_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/drl_ctrl.sv @@
// Sequencer for the dirty rectangle list.
`timescale 1ns / 1ps
module drl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  drl_pkg::op_type         req_op,
   input  logic                    rsp_space,
   output drl_pkg::drl_cmd_type    cmd,
   input  drl_pkg::drl_status_type status
);
   import drl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_FINAL, ST_ZERO, ST_READ
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      cmd.code  = CMD_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.code = CMD_START;
               op_in    = req_op;
               state_in = (req_op == OP_READ) ? ST_READ : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done || status.stop) begin
               state_in = ST_FINAL;
            end else begin
               cmd.code = CMD_STEP;
            end
         end
         ST_FINAL: begin
            // hold until the result register is free
            if (rsp_space) begin
               cmd.code = CMD_FINAL;
               state_in = (op_ff == OP_CLIP) ? ST_ZERO : ST_IDLE;
            end
         end
         ST_ZERO: begin
            // sweep vacated slots, then report
            if (status.zero_done) begin
               if (rsp_space) begin
                  cmd.code = CMD_EMIT;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.code = CMD_ZERO;
            end
         end
         ST_READ: begin
            if (rsp_space) begin
               cmd.code = CMD_EMIT;
               if (status.read_last || status.read_empty) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end
endmodule

@@ design/drl_dpath.sv @@
// Rectangle store, scan unit and result register.
`timescale 1ns / 1ps
module drl_dpath #(
   parameter int MAX_RECTS  = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  drl_pkg::drl_cmd_type    cmd,
   output drl_pkg::drl_status_type status,
   input  drl_pkg::op_type         req_op,
   input  logic signed [15:0]      req_rect_left,
   input  logic signed [15:0]      req_rect_top,
   input  logic signed [15:0]      req_rect_right,
   input  logic signed [15:0]      req_rect_bottom,
   input  logic                    req_only_test,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_space,
   output logic signed [15:0]      rsp_out_left,
   output logic signed [15:0]      rsp_out_top,
   output logic signed [15:0]      rsp_out_right,
   output logic signed [15:0]      rsp_out_bottom,
   output logic                    rsp_hit,
   output logic [4:0]              rsp_entry_total,
   output logic                    rsp_overflow,
   output logic                    rsp_last
);
   import drl_pkg::*;

   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 2);
   localparam int CB = COORD_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_RECTS - 1);
   localparam logic [CW-1:0] FULL    = CW'(MAX_RECTS);
   localparam logic signed [CB:0] HI = (CB+1)'((64'sd1 <<< (CB - 1)) - 1);
   localparam logic signed [CB:0] LO = -HI - 1;

   typedef struct packed {
      logic signed [CB-1:0] l, t, r, b;
   } box_type;

   // store
   box_type mem [MAX_RECTS];
   box_type rd_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] kept_ff, kept_in;
   op_type        op_ff, op_in;
   box_type       arg_ff, arg_in;
   box_type       acc_ff, acc_in;
   logic          test_ff, test_in;
   logic          hit_ff, hit_in;
   logic          found_ff, found_in;
   logic          first_ff, first_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   box_type       wr_data;
   logic [IW-1:0] rd_addr;

   box_type o_box_ff, o_box_in;
   logic    o_valid_ff, o_valid_in, o_hit_ff, o_hit_in, o_ovf_ff, o_ovf_in, o_last_ff;
   logic    o_last_in;
   logic [4:0] o_tot_ff, o_tot_in;

   box_type meet, join_ab, shifted, fin_box;
   logic    meet_ok, e_empty, a_empty;

   function automatic logic emp(box_type x);
      return (x.r <= x.l) || (x.b <= x.t);
   endfunction

   function automatic logic signed [CB-1:0] sat(logic signed [CB-1:0] a,
                                                  logic signed [CB-1:0] d);
      logic signed [CB:0] s;
      s = (CB+1)'(a) + (CB+1)'(d);
      if (s > HI) return HI[CB-1:0];
      if (s < LO) return LO[CB-1:0];
      return s[CB-1:0];
   endfunction

   // Combine the entry read this cycle with the operand
   always_comb begin
      meet.l  = (rd_ff.l > arg_ff.l) ? rd_ff.l : arg_ff.l;
      meet.t  = (rd_ff.t > arg_ff.t) ? rd_ff.t : arg_ff.t;
      meet.r  = (rd_ff.r < arg_ff.r) ? rd_ff.r : arg_ff.r;
      meet.b  = (rd_ff.b < arg_ff.b) ? rd_ff.b : arg_ff.b;
      meet_ok = !emp(meet);
      e_empty = emp(rd_ff);
      a_empty = emp(arg_ff);
      if (e_empty && a_empty) join_ab = '0;
      else if (e_empty) join_ab = arg_ff;
      else if (a_empty) join_ab = rd_ff;
      else begin
         join_ab.l = (rd_ff.l < arg_ff.l) ? rd_ff.l : arg_ff.l;
         join_ab.t = (rd_ff.t < arg_ff.t) ? rd_ff.t : arg_ff.t;
         join_ab.r = (rd_ff.r > arg_ff.r) ? rd_ff.r : arg_ff.r;
         join_ab.b = (rd_ff.b > arg_ff.b) ? rd_ff.b : arg_ff.b;
      end
      shifted.l = sat(rd_ff.l, arg_ff.l);
      shifted.r = sat(rd_ff.r, arg_ff.l);
      shifted.t = sat(rd_ff.t, arg_ff.t);
      shifted.b = sat(rd_ff.b, arg_ff.t);
   end

   // union of accumulator with entry (entry first per model)
   box_type uni;
   logic    u_acc_empty;
   always_comb begin
      u_acc_empty = emp(acc_ff);
      if (e_empty && u_acc_empty) uni = '0;
      else if (e_empty) uni = acc_ff;
      else if (u_acc_empty) uni = rd_ff;
      else begin
         uni.l = (rd_ff.l < acc_ff.l) ? rd_ff.l : acc_ff.l;
         uni.t = (rd_ff.t < acc_ff.t) ? rd_ff.t : acc_ff.t;
         uni.r = (rd_ff.r > acc_ff.r) ? rd_ff.r : acc_ff.r;
         uni.b = (rd_ff.b > acc_ff.b) ? rd_ff.b : acc_ff.b;
      end
   end

   assign rsp_space = !o_valid_ff || rsp_ready;

   // entry of the current scan step: rd_ff holds entry idx_ff-1 (first_ff clear)
   logic [CW-1:0] cur_idx;
   assign cur_idx = idx_ff - CW'(1);

   always_comb begin
      status.scan_done  = !first_ff && (idx_ff > count_ff);
      status.stop       = found_ff;
      status.zero_done  = (idx_ff >= count_ff);
      status.read_last  = (idx_ff + CW'(1) >= count_ff);
      status.read_empty = (count_ff == '0);
   end

   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      kept_in    = kept_ff;
      op_in      = op_ff;
      arg_in     = arg_ff;
      acc_in     = acc_ff;
      test_in    = test_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_addr    = idx_ff[IW-1:0];
      o_valid_in = o_valid_ff && !rsp_ready;
      o_box_in   = o_box_ff;
      o_hit_in   = o_hit_ff;
      o_ovf_in   = o_ovf_ff;
      o_last_in  = o_last_ff;
      o_tot_in   = o_tot_ff;
      fin_box    = '0;
      if (idx_ff >= FULL) rd_addr = LAST_IDX;

      unique case (cmd.code)
         CMD_START: begin
            op_in    = req_op;
            arg_in   = box_type'({CB'(req_rect_left), CB'(req_rect_top),
                                  CB'(req_rect_right), CB'(req_rect_bottom)});
            test_in  = req_only_test;
            acc_in   = '0;
            hit_in   = 1'b0;
            found_in = 1'b0;
            first_in = 1'b1;
            idx_in   = '0;
            kept_in  = '0;
            rd_addr  = '0;
            if (req_op == OP_READ) first_in = 1'b0;
         end
         CMD_STEP: begin
            // read entry idx_ff; it is in rd_ff next cycle as entry idx_in-1
            first_in = 1'b0;
            idx_in   = idx_ff + CW'(1);
            rd_addr  = (idx_ff >= FULL) ? LAST_IDX : idx_ff[IW-1:0];
            if (!first_ff && cur_idx < count_ff) begin
               unique case (op_ff)
                  OP_ADD: if (meet_ok) begin
                     found_in = 1'b1;
                     acc_in   = join_ab;
                     wr_en    = 1'b1;
                     wr_addr  = cur_idx[IW-1:0];
                     wr_data  = join_ab;
                  end
                  OP_CLIP: if (meet_ok) begin
                     hit_in = 1'b1;
                     if (test_ff) found_in = 1'b1;
                     else begin
                        wr_en   = 1'b1;
                        wr_addr = kept_ff[IW-1:0];
                        wr_data = meet;
                        kept_in = kept_ff + CW'(1);
                     end
                  end
                  OP_SHIFT: begin
                     wr_en   = 1'b1;
                     wr_addr = cur_idx[IW-1:0];
                     wr_data = shifted;
                  end
                  OP_UNION: acc_in = uni;
                  default: ;
               endcase
            end
         end
         CMD_FINAL: begin
            o_hit_in  = 1'b0;
            o_ovf_in  = 1'b0;
            o_last_in = 1'b1;
            unique case (op_ff)
               OP_ADD: begin
                  if (found_ff) begin
                     fin_box  = acc_ff;
                     o_hit_in = 1'b1;
                  end else if (count_ff < FULL) begin
                     fin_box  = arg_ff;
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IW-1:0];
                     wr_data  = arg_ff;
                     count_in = count_ff + CW'(1);
                  end else begin
                     // list full: last entry was read last in the scan
                     fin_box  = join_ab;
                     wr_en    = 1'b1;
                     wr_addr  = LAST_IDX;
                     wr_data  = join_ab;
                     o_ovf_in = 1'b1;
                  end
               end
               OP_UNION: fin_box = acc_ff;
               OP_CLEAR: count_in = '0;
               default: fin_box = '0;
            endcase
            o_box_in   = fin_box;
            if (op_ff == OP_CLIP) begin
               // prepare zero sweep from kept onwards
               idx_in = count_ff;
               if (!test_ff && count_ff != '0) begin
                  idx_in  = kept_ff;
                  hit_in  = kept_ff != '0;
               end
            end else begin
               o_valid_in = 1'b1;
               o_tot_in   = 5'(count_in);
            end
            if (op_ff == OP_CLEAR) begin
               idx_in = '0;
            end
         end
         CMD_ZERO: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = '0;
            idx_in  = idx_ff + CW'(1);
         end
         CMD_EMIT: begin
            o_valid_in = 1'b1;
            o_hit_in   = 1'b0;
            o_ovf_in   = 1'b0;
            if (op_ff == OP_CLIP) begin
               o_box_in  = '0;
               o_hit_in  = hit_ff;
               o_last_in = 1'b1;
               if (!test_ff && count_ff != '0) count_in = kept_ff;
               o_tot_in  = 5'(count_in);
            end else begin
               // read out: rd_ff holds entry idx_ff
               o_box_in  = (count_ff == '0) ? box_type'('0) : rd_ff;
               o_last_in = status.read_last || status.read_empty;
               o_tot_in  = 5'(count_ff);
               idx_in    = idx_ff + CW'(1);
               rd_addr   = (idx_ff + CW'(1) >= FULL) ? LAST_IDX
                                                     : idx_ff[IW-1:0] + IW'(1);
            end
         end
         default: ;
      endcase
   end

   // Write the store and register the read, forwarding a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (wr_en && wr_addr == rd_addr) rd_ff <= wr_data;
      else rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         o_valid_ff <= 1'b0;
         first_ff   <= 1'b0;
         found_ff   <= 1'b0;
         idx_ff     <= '0;
         kept_ff    <= '0;
         op_ff      <= OP_ADD;
         hit_ff     <= 1'b0;
         test_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         o_valid_ff <= o_valid_in;
         first_ff   <= first_in;
         found_ff   <= found_in;
         idx_ff     <= idx_in;
         kept_ff    <= kept_in;
         op_ff      <= op_in;
         hit_ff     <= hit_in;
         test_ff    <= test_in;
      end
   end

   always_ff @(posedge clock) begin
      arg_ff    <= arg_in;
      acc_ff    <= acc_in;
      o_box_ff  <= o_box_in;
      o_hit_ff  <= o_hit_in;
      o_ovf_ff  <= o_ovf_in;
      o_last_ff <= o_last_in;
      o_tot_ff  <= o_tot_in;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_out_left    = 16'(o_box_ff.l);
   assign rsp_out_top     = 16'(o_box_ff.t);
   assign rsp_out_right   = 16'(o_box_ff.r);
   assign rsp_out_bottom  = 16'(o_box_ff.b);
   assign rsp_hit         = o_hit_ff;
   assign rsp_entry_total = o_tot_ff;
   assign rsp_overflow    = o_ovf_ff;
   assign rsp_last        = o_last_ff;
endmodule

@@ design/dirty_rect_list_core.sv @@
// Top level of the dirty rectangle list.
`timescale 1ns / 1ps
// Holds up to MAX_RECTS rectangles in a store with one write port and one
// registered read port, and works one operation at a time. Each operation
// scans the stored entries one per cycle through the store's registered
// read port; its final step waits while an earlier result is still held in
// the output register. Clip then zeroes each vacated slot in turn, and
// read-out gives one result per cycle while the output is taken.
// Clear only resets the count: entries past the count are never read.
module dirty_rect_list_core #(
   parameter int MAX_RECTS  = 16,
   parameter int COORD_BITS = 16
) (
   input logic clock,
   input logic reset,
   drl_if.sink   req,
   drl_if.source rsp
);
   import drl_pkg::*;

   drl_cmd_type    cmd;
   drl_status_type status;
   logic           rsp_space;

   drl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_op    (op_type'(req.data.op)),
      .rsp_space (rsp_space),
      .cmd       (cmd),
      .status    (status)
   );

   drl_dpath #(.MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (op_type'(req.data.op)),
      .req_rect_left   (req.data.rect_left),
      .req_rect_top    (req.data.rect_top),
      .req_rect_right  (req.data.rect_right),
      .req_rect_bottom (req.data.rect_bottom),
      .req_only_test   (req.data.only_test),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_space       (rsp_space),
      .rsp_out_left    (rsp.data.out_left),
      .rsp_out_top     (rsp.data.out_top),
      .rsp_out_right   (rsp.data.out_right),
      .rsp_out_bottom  (rsp.data.out_bottom),
      .rsp_hit         (rsp.data.hit),
      .rsp_entry_total (rsp.data.entry_total),
      .rsp_overflow    (rsp.data.overflow),
      .rsp_last        (rsp.data.last)
   );
endmodule

@@ design/drl_checker.sv @@
// Port-level checks for the dirty rectangle list, bound to the top level.
`timescale 1ns / 1ps
module drl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last,
   input logic       rsp_overflow,
   input logic       rsp_hit
);
   // no new transaction taken in the cycle right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back accept");
   // overflow and hit never both set
   a_ovf_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_hit))
      else $error("overflow with hit");
   // a held result stays valid and keeps its last flag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
      else $error("result dropped");
   // no accept while a result is pending before its last
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("accept during read-out");
endmodule

bind dirty_rect_list_core drl_checker u_drl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_last        (rsp.data.last),
   .rsp_overflow    (rsp.data.overflow),
   .rsp_hit         (rsp.data.hit)
);

@@ dv/tb_dirty_rect_list_core.sv @@
// Self-checking testbench for the dirty rectangle list core.
`timescale 1ns / 1ps
module tb_dirty_rect_list_core;
   import drl_pkg::*;

   localparam int NUM_RECTS   = 16;
   localparam int COORD_W     = 16;
   localparam int RAND_ITEMS  = 110;
   localparam int IDLE_LIMIT  = 3000;

   typedef struct packed {
      op_type                    op;
      logic signed [COORD_W-1:0] rect_left;
      logic signed [COORD_W-1:0] rect_top;
      logic signed [COORD_W-1:0] rect_right;
      logic signed [COORD_W-1:0] rect_bottom;
      logic                      only_test;
   } req_t;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_left;
      logic signed [COORD_W-1:0] out_top;
      logic signed [COORD_W-1:0] out_right;
      logic signed [COORD_W-1:0] out_bottom;
      logic                      hit;
      logic [4:0]                entry_total;
      logic                      overflow;
      logic                      last;
   } rsp_t;

   typedef struct {
      int l;
      int t;
      int r;
      int b;
   } box_t;

   typedef struct {
      req_t item;
      bit   typed;
      rsp_t exp;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drl_if #(.payload_type(req_t)) req_ch ();
   drl_if #(.payload_type(rsp_t)) rsp_ch ();

   dirty_rect_list_core #(
      .MAX_RECTS (NUM_RECTS),
      .COORD_BITS(COORD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #2 clock = ~clock;

   // Shadow copy of the rectangle store
   box_t        shadow_rects[NUM_RECTS];
   int unsigned shadow_count;
   rsp_t        pending_rsp[$];
   stim_row_t   directed_rows[$];
   int          error_count = 0;
   int          hold_request = 0;
   bit          accepted_any;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic bit box_empty(box_t a);
      return a.r <= a.l || a.b <= a.t;
   endfunction

   function automatic box_t box_union(box_t a, box_t b);
      box_t z;
      z = '{0, 0, 0, 0};
      if (box_empty(a) && box_empty(b)) return z;
      if (box_empty(a)) return b;
      if (box_empty(b)) return a;
      z.l = a.l < b.l ? a.l : b.l;
      z.t = a.t < b.t ? a.t : b.t;
      z.r = a.r > b.r ? a.r : b.r;
      z.b = a.b > b.b ? a.b : b.b;
      return z;
   endfunction

   // Intersection; returns 0 and a zero box when the overlap is empty
   function automatic bit box_overlap(box_t a, box_t b, output box_t m);
      m.l = a.l > b.l ? a.l : b.l;
      m.t = a.t > b.t ? a.t : b.t;
      m.r = a.r < b.r ? a.r : b.r;
      m.b = a.b < b.b ? a.b : b.b;
      if (box_empty(m)) begin
         m = '{0, 0, 0, 0};
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic int saturate(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic rsp_t make_rsp(box_t b, bit hit, bit ovf, bit last);
      rsp_t r;
      r.out_left    = b.l[COORD_W-1:0];
      r.out_top     = b.t[COORD_W-1:0];
      r.out_right   = b.r[COORD_W-1:0];
      r.out_bottom  = b.b[COORD_W-1:0];
      r.hit         = hit;
      r.entry_total = shadow_count[4:0];
      r.overflow    = ovf;
      r.last        = last;
      return r;
   endfunction

   function automatic void clear_shadow();
      foreach (shadow_rects[i]) shadow_rects[i] = '{0, 0, 0, 0};
      shadow_count = 0;
   endfunction

   // Update the shadow store and queue the results one operation causes
   function automatic void predict_rect_op(req_t it);
      box_t        arg, zero, tmp;
      bit          hit;
      int unsigned kept;
      arg  = '{int'(it.rect_left), int'(it.rect_top), int'(it.rect_right),
               int'(it.rect_bottom)};
      zero = '{0, 0, 0, 0};
      hit  = 1'b0;
      case (it.op)
         OP_ADD: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (box_overlap(shadow_rects[i], arg, tmp)) begin
                  shadow_rects[i] = box_union(shadow_rects[i], arg);
                  pending_rsp.push_back(make_rsp(shadow_rects[i], 1'b1, 1'b0, 1'b1));
                  return;
               end
            end
            if (shadow_count < NUM_RECTS) begin
               shadow_rects[shadow_count] = arg;
               shadow_count++;
               pending_rsp.push_back(make_rsp(arg, 1'b0, 1'b0, 1'b1));
            end else begin
               shadow_rects[NUM_RECTS-1] = box_union(shadow_rects[NUM_RECTS-1], arg);
               pending_rsp.push_back(make_rsp(shadow_rects[NUM_RECTS-1], 1'b0, 1'b1, 1'b1));
            end
            return;
         end
         OP_CLIP: begin
            if (shadow_count != 0 && it.only_test) begin
               for (int i = 0; i < shadow_count; i++)
                  if (box_overlap(shadow_rects[i], arg, tmp)) hit = 1'b1;
            end else if (shadow_count != 0) begin
               kept = 0;
               for (int i = 0; i < shadow_count; i++) begin
                  if (box_overlap(shadow_rects[i], arg, tmp)) begin
                     shadow_rects[kept] = tmp;
                     kept++;
                  end
               end
               if (kept == 0) begin
                  clear_shadow();
               end else begin
                  for (int i = kept; i < shadow_count; i++) shadow_rects[i] = zero;
                  shadow_count = kept;
                  hit = 1'b1;
               end
            end
         end
         OP_SHIFT: begin
            for (int i = 0; i < shadow_count; i++) begin
               shadow_rects[i].l = saturate(shadow_rects[i].l + arg.l);
               shadow_rects[i].r = saturate(shadow_rects[i].r + arg.l);
               shadow_rects[i].t = saturate(shadow_rects[i].t + arg.t);
               shadow_rects[i].b = saturate(shadow_rects[i].b + arg.t);
            end
         end
         OP_CLEAR: clear_shadow();
         OP_UNION: begin
            tmp = zero;
            for (int i = 0; i < shadow_count; i++) tmp = box_union(shadow_rects[i], tmp);
            pending_rsp.push_back(make_rsp(tmp, 1'b0, 1'b0, 1'b1));
            return;
         end
         OP_READ: begin
            if (shadow_count != 0) begin
               for (int i = 0; i < shadow_count; i++)
                  pending_rsp.push_back(make_rsp(shadow_rects[i], 1'b0, 1'b0,
                                                 i + 1 == shadow_count));
               return;
            end
         end
         default: ;
      endcase
      pending_rsp.push_back(make_rsp(zero, hit, 1'b0, 1'b1));
   endfunction

   function automatic req_t make_req(op_type op, int l, int t, int r, int b, bit ot);
      req_t it;
      it.op          = op;
      it.rect_left   = l[COORD_W-1:0];
      it.rect_top    = t[COORD_W-1:0];
      it.rect_right  = r[COORD_W-1:0];
      it.rect_bottom = b[COORD_W-1:0];
      it.only_test   = ot;
      return it;
   endfunction

   function automatic void add_row(req_t it, bit typed = 1'b0, rsp_t exp = '0);
      stim_row_t row;
      row.item  = it;
      row.typed = typed;
      row.exp   = exp;
      directed_rows.push_back(row);
   endfunction

   // Zero-rectangle response with given flags, typed in by hand
   function automatic rsp_t zero_rsp(bit hit, int total);
      rsp_t r;
      r             = '0;
      r.hit         = hit;
      r.entry_total = total[4:0];
      r.last        = 1'b1;
      return r;
   endfunction

   // Offer one transaction after a random gap; return once it is taken
   task automatic send_item(input req_t it);
      int gap;
      case ($urandom_range(0, 19))
         0:       gap = $urandom_range(15, 40);
         1, 2, 3: gap = $urandom_range(1, 4);
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      predict_rect_op(it);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic int rand_coord();
      if ($urandom_range(0, 9) == 0) return $signed($urandom_range(0, 65535) - 32768);
      return $urandom_range(0, 160);
   endfunction

   function automatic req_t rand_item();
      int     l, t, pick;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 55)      op = OP_ADD;
      else if (pick < 65) op = OP_CLIP;
      else if (pick < 73) op = OP_SHIFT;
      else if (pick < 77) op = OP_CLEAR;
      else if (pick < 85) op = OP_UNION;
      else if (pick < 95) op = OP_READ;
      else                op = $urandom_range(0, 1) ? OP_NOP6 : OP_NOP7;
      l = rand_coord();
      t = rand_coord();
      if (op == OP_SHIFT && $urandom_range(0, 3) != 0)
         return make_req(op, $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                         rand_coord(), rand_coord(), $urandom_range(0, 1));
      if (op == OP_CLIP)
         return make_req(op, $urandom_range(0, 60), $urandom_range(0, 60),
                         $urandom_range(60, 200), $urandom_range(60, 200),
                         $urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0)
         return make_req(op, l, t, rand_coord(), rand_coord(), $urandom_range(0, 1));
      return make_req(op, l, t, l + $urandom_range(0, 12), t + $urandom_range(0, 12),
                      $urandom_range(0, 1));
   endfunction

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         case ($urandom_range(0, 39))
            0:          hold_left = $urandom_range(10, 40);
            1, 2, 3, 4: hold_left = $urandom_range(1, 3);
            default:    hold_left = 0;
         endcase
      end
   end

   // Compare each result against the oldest expectation
   always @(posedge clock) begin
      rsp_t got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result, out_left", got.out_left, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.out_left !== want.out_left)
               report_mismatch("out_left", got.out_left, want.out_left);
            if (got.out_top !== want.out_top)
               report_mismatch("out_top", got.out_top, want.out_top);
            if (got.out_right !== want.out_right)
               report_mismatch("out_right", got.out_right, want.out_right);
            if (got.out_bottom !== want.out_bottom)
               report_mismatch("out_bottom", got.out_bottom, want.out_bottom);
            if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.entry_total !== want.entry_total)
               report_mismatch("entry_total", got.entry_total, want.entry_total);
            if (got.overflow !== want.overflow)
               report_mismatch("overflow", got.overflow, want.overflow);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_t row;
      clear_shadow();

      // Directed table: empty-list cases, merges, extremes, shift, clip, read-out and clear
      add_row(make_req(OP_READ, 0, 0, 0, 0, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_UNION, 0, 0, 0, 0, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_NOP6, 1, 2, 3, 4, 1), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_NOP7, -1, -1, -1, -1, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_CLIP, 0, 0, 100, 100, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_ADD, 0, 0, 10, 10, 0));
      add_row(make_req(OP_ADD, 5, 5, 20, 20, 0));
      add_row(make_req(OP_ADD, 3, 3, 3, 9, 0));
      add_row(make_req(OP_ADD, 100, 100, 200, 200, 0));
      add_row(make_req(OP_ADD, -32768, -32768, 32767, 32767, 1));
      add_row(make_req(OP_ADD, 500, 500, 600, 600, 0));
      add_row(make_req(OP_SHIFT, 32767, 32767, 0, 0, 0));
      add_row(make_req(OP_READ, 0, 0, 0, 0, 0));
      add_row(make_req(OP_SHIFT, -32768, -32768, -1, -1, 1));
      add_row(make_req(OP_UNION, 0, 0, 0, 0, 0));
      add_row(make_req(OP_CLIP, -10, -10, 10, 10, 1));
      add_row(make_req(OP_CLIP, -32768, -32768, 0, 0, 0));
      add_row(make_req(OP_READ, 0, 0, 0, 0, 0));
      add_row(make_req(OP_CLIP, 5, 5, 6, 6, 0));
      add_row(make_req(OP_READ, 0, 0, 0, 0, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_ADD, 1, 1, 4, 4, 0));
      add_row(make_req(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1, zero_rsp(0, 0));
      add_row(make_req(OP_UNION, 0, 0, 0, 0, 0), 1'b1, zero_rsp(0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         send_item(row.item);
         // Typed rows replace the predicted value with the hand-written one
         if (row.typed) begin
            pending_rsp.pop_back();
            pending_rsp.push_back(row.exp);
         end
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         // Fill the list past full with disjoint rectangles, then hold off the receiver and read back
         if (n == 40) begin
            for (int j = 0; j < NUM_RECTS + 3; j++)
               send_item(make_req(OP_ADD, 1000 + 20 * j, 1000, 1010 + 20 * j, 1010, 0));
            hold_request = 300;
            for (int j = 0; j < 6; j++) send_item(make_req(OP_READ, 0, 0, 0, 0, 0));
         end
         // Drain all results before going on
         if (n == 100) begin
            req_ch.valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
            send_item(make_req(OP_READ, 0, 0, 0, 0, 0));
         end
         send_item(rand_item());
      end
      req_ch.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

@@ files.f @@
design/drl_pkg.sv
design/drl_if.sv
design/drl_ctrl.sv
design/drl_dpath.sv
design/dirty_rect_list_core.sv
design/drl_checker.sv
dv/tb_dirty_rect_list_core.sv
